// ----- src/slt_pkg.sv -----
// Shared constants, codes and memory-port types of the link table builder.
// No dependencies; imported by every other file of the block.
`default_nettype none

package slt_pkg;

   localparam int ROW_DEPTH   = 1024;
   localparam int LINK_DEPTH  = 4096;
   localparam int TARGET_BITS = 16;

   // derived storage widths
   localparam int OFF_AW  = $clog2(ROW_DEPTH + 1);   // offset table address
   localparam int OFF_W   = $clog2(LINK_DEPTH + 1);  // offset / link count value
   localparam int LINK_AW = $clog2(LINK_DEPTH);      // link store address

   // port field widths
   localparam int CMD_W  = 3;
   localparam int ROW_W  = 10;
   localparam int TGT_W  = 16;
   localparam int POS_W  = 12;
   localparam int CNT_W  = 13;
   localparam int STAT_W = 3;

   localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INDEX = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
   localparam logic [STAT_W-1:0] ST_ORDER = 3'd1;
   localparam logic [STAT_W-1:0] ST_ROW   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
   localparam logic [STAT_W-1:0] ST_POS   = 3'd4;

   typedef struct packed {
      logic              en;
      logic [OFF_AW-1:0] addr;
      logic [OFF_W-1:0]  data;
   } off_wr_type;

   typedef struct packed {
      logic              en;
      logic [OFF_AW-1:0] addr_a;
      logic [OFF_AW-1:0] addr_b;
   } off_rd_type;

   typedef struct packed {
      logic                   en;
      logic [LINK_AW-1:0]     addr;
      logic [TARGET_BITS-1:0] data;
   } link_wr_type;

   typedef struct packed {
      logic               en;
      logic [LINK_AW-1:0] addr;
   } link_rd_type;

endpackage

`default_nettype wire

// ----- src/slt_offset_ram.sv -----
// Row offset table: one write port, two registered read ports.
// Depends on slt_pkg.
`default_nettype none

module slt_offset_ram
   import slt_pkg::*;
(
   input  wire logic             clock,
   input  wire off_wr_type       wr,
   input  wire off_rd_type       rd,
   output logic [OFF_W-1:0]      rd_a_data,
   output logic [OFF_W-1:0]      rd_b_data
);

   logic [OFF_W-1:0] mem [ROW_DEPTH+1];
   logic [OFF_W-1:0] rd_a_ff;
   logic [OFF_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_a_ff <= mem[rd.addr_a];
         rd_b_ff <= mem[rd.addr_b];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ----- src/slt_link_ram.sv -----
// Flat link store: one write port, one registered read port.
// Depends on slt_pkg.
`default_nettype none

module slt_link_ram
   import slt_pkg::*;
(
   input  wire logic              clock,
   input  wire link_wr_type       wr,
   input  wire link_rd_type       rd,
   output logic [TARGET_BITS-1:0] rd_data
);

   logic [TARGET_BITS-1:0] mem [LINK_DEPTH];
   logic [TARGET_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// ----- src/slt_ctrl.sv -----
// Command sequencer: decodes commands, fills skipped offsets, runs lookups.
// Depends on slt_pkg; drives slt_offset_ram and slt_link_ram.
`default_nettype none

module slt_ctrl
   import slt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [ROW_W-1:0]  req_row,
   input  wire logic [TGT_W-1:0]  req_target,
   input  wire logic [POS_W-1:0]  req_position,
   output logic                   rsp_valid,
   output logic [CNT_W-1:0]       rsp_link_count,
   output logic [TGT_W-1:0]       rsp_link_target,
   output logic [CNT_W-1:0]       rsp_stored_total,
   output logic [STAT_W-1:0]      rsp_status,
   output off_wr_type             off_wr,
   output off_rd_type             off_rd,
   input  wire logic [OFF_W-1:0]  off_a_data,
   input  wire logic [OFF_W-1:0]  off_b_data,
   output link_wr_type            link_wr,
   output link_rd_type            link_rd,
   input  wire logic [TARGET_BITS-1:0] link_data
);

   typedef enum logic [1:0] {S_IDLE, S_FILL, S_LOOKUP, S_FETCH} state_type;

   localparam logic [OFF_AW-1:0] ROW_LIMIT  = OFF_AW'(ROW_DEPTH);
   localparam logic [OFF_W-1:0]  LINK_LIMIT = OFF_W'(LINK_DEPTH);

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [TARGET_BITS-1:0] target_ff, target_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [OFF_AW-1:0]  nxt_ff, nxt_in;      // last row + 1; 0 when empty
   logic [OFF_W-1:0]   total_ff, total_in;
   logic [OFF_AW-1:0]  ptr_ff, ptr_in;      // offset entry being filled
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [TGT_W-1:0]   rsp_target_ff, rsp_target_in;
   logic [CNT_W-1:0]   rsp_total_ff, rsp_total_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;

   logic              accept;
   logic [OFF_AW-1:0] row_ext, row_nx, end_addr;
   logic              row_ok, behind, same, known, full, fill_last;
   logic [OFF_W-1:0]  lo, cnt, at;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;

   assign row_ext = OFF_AW'(req_row);
   assign row_nx  = row_ext + 1'b1;
   assign row_ok  = row_ext < ROW_LIMIT;
   assign behind  = row_nx < nxt_ff;
   assign same    = row_nx == nxt_ff;
   assign known   = row_ext < nxt_ff;
   assign full    = total_ff >= LINK_LIMIT;

   assign end_addr  = OFF_AW'(row_ff) + 1'b1;
   assign fill_last = ptr_ff == end_addr;

   // entry 0 is never written after reset except to zero, so read it as zero
   assign lo  = (row_ff == '0) ? '0 : off_a_data;
   assign cnt = off_b_data - lo;
   assign at  = lo + OFF_W'(pos_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      target_in     = target_ff;
      pos_in        = pos_ff;
      nxt_in        = nxt_ff;
      total_in      = total_ff;
      ptr_in        = ptr_ff;
      rsp_valid_in  = 1'b0;
      rsp_count_in  = rsp_count_ff;
      rsp_target_in = rsp_target_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      off_wr        = '0;
      off_rd.en     = 1'b0;
      off_rd.addr_a = row_ext;
      off_rd.addr_b = row_nx;
      link_wr       = '0;
      link_rd.en    = 1'b0;
      link_rd.addr  = LINK_AW'(at);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd;
               row_in        = req_row;
               target_in     = TARGET_BITS'(req_target);
               pos_in        = req_position;
               rsp_count_in  = '0;
               rsp_target_in = '0;
               rsp_total_in  = CNT_W'(total_ff);
               rsp_status_in = ST_OK;
               unique case (req_cmd) inside
                  CMD_ADD, CMD_CLOSE: begin
                     if (!row_ok) begin
                        rsp_status_in = ST_ROW;
                        rsp_valid_in  = 1'b1;
                     end else if (behind) begin
                        rsp_status_in = ST_ORDER;
                        rsp_valid_in  = 1'b1;
                     end else if (req_cmd == CMD_ADD && full) begin
                        rsp_status_in = ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (req_cmd == CMD_CLOSE && same) begin
                        rsp_valid_in  = 1'b1;
                     end else begin
                        // same-row add only bumps its end entry
                        ptr_in   = same ? nxt_ff : nxt_ff + 1'b1;
                        state_in = S_FILL;
                     end
                  end
                  CMD_CLEAR: begin
                     nxt_in       = '0;
                     total_in     = '0;
                     rsp_total_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_COUNT, CMD_INDEX: begin
                     if (!row_ok) begin
                        rsp_status_in = ST_ROW;
                        rsp_valid_in  = 1'b1;
                     end else if (!known) begin
                        if (req_cmd == CMD_INDEX) begin
                           rsp_status_in = ST_POS;
                        end
                        rsp_valid_in = 1'b1;
                     end else begin
                        off_rd.en = 1'b1;
                        state_in  = S_LOOKUP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_FILL: begin
            off_wr.en   = 1'b1;
            off_wr.addr = ptr_ff;
            off_wr.data = (fill_last && cmd_ff == CMD_ADD) ? total_ff + 1'b1 : total_ff;
            ptr_in      = ptr_ff + 1'b1;
            if (fill_last) begin
               nxt_in = end_addr;
               if (cmd_ff == CMD_ADD) begin
                  link_wr.en   = 1'b1;
                  link_wr.addr = LINK_AW'(total_ff);
                  link_wr.data = target_ff;
                  total_in     = total_ff + 1'b1;
               end
               rsp_total_in = CNT_W'(total_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LOOKUP: begin
            rsp_count_in = CNT_W'(cnt);
            if (cmd_ff == CMD_COUNT) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (OFF_W'(pos_ff) >= cnt) begin
               rsp_status_in = ST_POS;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               link_rd.en = 1'b1;
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            rsp_target_in = TGT_W'(link_data);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nxt_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nxt_ff       <= nxt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      target_ff     <= target_in;
      pos_ff        <= pos_in;
      ptr_ff        <= ptr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_target_ff <= rsp_target_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_link_count   = rsp_count_ff;
   assign rsp_link_target  = rsp_target_ff;
   assign rsp_stored_total = rsp_total_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ----- src/sequential_link_table_builder.sv -----
// Link table builder in compressed sparse row form.
// A command is transferred on the rising edge where start is high and busy is
// low (req_cmd, req_row, req_target, req_position). Every command gives exactly
// one result, shown for one cycle with rsp_valid high; the receiver cannot
// hold it off, so it must take it in that cycle.
// Steps from transfer to result:
//   errors, clear, unused codes, close of the current row,
//   query of a row past the last: answered in S_IDLE
//   add to the current row: S_FILL writes its end entry
//   add or close from last row L to row R: S_FILL writes entries L+2..R+1
//   (L is -1 when empty); count query: S_LOOKUP; index query: S_LOOKUP
//   then S_FETCH (S_LOOKUP alone when the position is out of range).
// busy is high until the result is shown, so a new command may be transferred
// in the cycle the previous result appears. The offset table's single write
// port (one skipped row per cycle) and the registered memory reads set the pace.
// Reset (synchronous, active high) empties the table at once: no clearing
// pass, since only offset entries already written are ever used.
// Depends on slt_pkg, slt_ctrl, slt_offset_ram, slt_link_ram.
`default_nettype none

module sequential_link_table_builder
   import slt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [ROW_W-1:0]  req_row,
   input  wire logic [TGT_W-1:0]  req_target,
   input  wire logic [POS_W-1:0]  req_position,
   output logic                   rsp_valid,
   output logic [CNT_W-1:0]       rsp_link_count,
   output logic [TGT_W-1:0]       rsp_link_target,
   output logic [CNT_W-1:0]       rsp_stored_total,
   output logic [STAT_W-1:0]      rsp_status
);

   off_wr_type             off_wr;
   off_rd_type             off_rd;
   logic [OFF_W-1:0]       off_a_data;
   logic [OFF_W-1:0]       off_b_data;
   link_wr_type            link_wr;
   link_rd_type            link_rd;
   logic [TARGET_BITS-1:0] link_data;

   slt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_row          (req_row),
      .req_target       (req_target),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_link_count   (rsp_link_count),
      .rsp_link_target  (rsp_link_target),
      .rsp_stored_total (rsp_stored_total),
      .rsp_status       (rsp_status),
      .off_wr           (off_wr),
      .off_rd           (off_rd),
      .off_a_data       (off_a_data),
      .off_b_data       (off_b_data),
      .link_wr          (link_wr),
      .link_rd          (link_rd),
      .link_data        (link_data)
   );

   slt_offset_ram u_offset_ram (
      .clock     (clock),
      .wr        (off_wr),
      .rd        (off_rd),
      .rd_a_data (off_a_data),
      .rd_b_data (off_b_data)
   );

   slt_link_ram u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd      (link_rd),
      .rd_data (link_data)
   );

endmodule

`default_nettype wire

// ----- src/slt_checker.sv -----
// Port-level checks of the link table builder, bound to the top level.
// Depends on slt_pkg and sequential_link_table_builder.
`default_nettype none

module slt_checker
   import slt_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic [CMD_W-1:0]  req_cmd,
   input wire logic [ROW_W-1:0]  req_row,
   input wire logic [TGT_W-1:0]  req_target,
   input wire logic [POS_W-1:0]  req_position,
   input wire logic              rsp_valid,
   input wire logic [CNT_W-1:0]  rsp_link_count,
   input wire logic [TGT_W-1:0]  rsp_link_target,
   input wire logic [CNT_W-1:0]  rsp_stored_total,
   input wire logic [STAT_W-1:0] rsp_status
);

   // a transfer either starts work or answers in the next cycle
   a_transfer_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("transfer neither started work nor answered");

   // the block is free again once a result is shown
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // no result without a transfer or work in hand
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start) || $past(busy))
      else $error("result without a command");

   a_error_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_link_target == '0)
      else $error("failed command returned a target");

   a_full_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_stored_total == CNT_W'(LINK_DEPTH))
      else $error("store full reported below capacity");

endmodule

bind sequential_link_table_builder slt_checker u_slt_checker (.*);

`default_nettype wire
